// ----- rtl/btme_pkg.sv -----
// shared constants, opcode characters and word types of the bit tape executor
package btme_pkg;

  localparam int TAPE_BYTES     = 8192;
  localparam int TAPE_ADDR_BITS = $clog2(TAPE_BYTES);
  localparam int CURSOR_BITS    = TAPE_ADDR_BITS + 3;
  localparam int STACK_DEPTH    = 16;
  localparam int STACK_IDX_BITS = $clog2(STACK_DEPTH);
  localparam int LEVEL_BITS     = $clog2(STACK_DEPTH + 1);
  localparam int PC_BITS        = 16;
  localparam int SKIP_BITS      = 16;

  // instruction characters
  localparam logic [7:0] OP_FLIP  = 8'h2B; // +
  localparam logic [7:0] OP_READ  = 8'h2C; // ,
  localparam logic [7:0] OP_WRITE = 8'h3B; // ;
  localparam logic [7:0] OP_LEFT  = 8'h3C; // <
  localparam logic [7:0] OP_RIGHT = 8'h3E; // >
  localparam logic [7:0] OP_LOOP  = 8'h5B; // [
  localparam logic [7:0] OP_END   = 8'h5D; // ]

  typedef struct packed {
    logic [7:0]         kind;
    logic [PC_BITS-1:0] pc;
    logic [7:0]         in_byte;
  } in_word_t;

  typedef struct packed {
    logic [PC_BITS-1:0] next_pc;
    logic               out_valid;
    logic [7:0]         out_byte;
    logic               byte_taken;
    logic               stack_overflow;
    logic               skipping;
  } out_word_t;

  typedef struct packed {
    logic                      rd_en;
    logic [TAPE_ADDR_BITS-1:0] rd_addr;
    logic                      wr_en;
    logic [TAPE_ADDR_BITS-1:0] wr_addr;
    logic [7:0]                wr_data;
  } tape_req_t;

endpackage

// ----- rtl/btme_tape_ram.sv -----
// single port pair tape memory, one write and one registered read per cycle
module btme_tape_ram (
  input  logic                clk,
  input  btme_pkg::tape_req_t req,
  output logic [7:0]          rd_data
);

  logic [7:0] mem [btme_pkg::TAPE_BYTES];

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_data <= mem[req.rd_addr];
    end
  end

endmodule

// ----- rtl/btme_core.sv -----
// instruction execution: cursor, loop stack, bit buffers, skip mode, tape read-modify-write
module btme_core (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  btme_pkg::in_word_t   cmd,
  input  logic                 res_free,
  input  logic [7:0]           rd_data,
  output btme_pkg::tape_req_t  tape_req,
  output logic                 busy,
  output logic                 fire,
  output btme_pkg::out_word_t  res
);

  btme_pkg::in_word_t item;
  logic ex_valid;

  logic [btme_pkg::CURSOR_BITS-1:0] cursor, cursor_next;
  logic [btme_pkg::PC_BITS-1:0]     stack [btme_pkg::STACK_DEPTH];
  logic [btme_pkg::LEVEL_BITS-1:0]  level, level_next;
  logic [7:0]                       in_buf, in_buf_next;
  logic [3:0]                       in_cnt, in_cnt_next;
  logic [7:0]                       out_buf, out_buf_next;
  logic [2:0]                       out_cnt, out_cnt_next;
  logic                             skip_active, skip_active_next;
  logic [btme_pkg::SKIP_BITS-1:0]   skip_depth, skip_depth_next;

  logic [btme_pkg::STACK_IDX_BITS-1:0] top_idx;
  logic [2:0] bit_sel;
  logic       cur_bit;
  logic       new_bit;
  logic       bit_wr;
  logic       push;
  logic [7:0] byte_wr;

  assign bit_sel = cursor[2:0];
  assign cur_bit = rd_data[bit_sel];
  assign top_idx = btme_pkg::STACK_IDX_BITS'(level - 1'b1);
  assign busy    = ex_valid;
  assign fire    = ex_valid && res_free;

  always_comb begin
    cursor_next      = cursor;
    level_next       = level;
    in_buf_next      = in_buf;
    in_cnt_next      = in_cnt;
    out_buf_next     = out_buf;
    out_cnt_next     = out_cnt;
    skip_active_next = skip_active;
    skip_depth_next  = skip_depth;
    new_bit          = cur_bit;
    bit_wr           = 1'b0;
    push             = 1'b0;
    res              = '0;
    res.next_pc      = item.pc + 1'b1;
    if (skip_active) begin
      if (item.kind == btme_pkg::OP_LOOP) begin
        if (skip_depth != '1) begin
          skip_depth_next = skip_depth + 1'b1;
        end
      end else if (item.kind == btme_pkg::OP_END) begin
        if (skip_depth == '0) begin
          skip_active_next = 1'b0;
        end else begin
          skip_depth_next = skip_depth - 1'b1;
        end
      end
    end else begin
      case (item.kind)
        btme_pkg::OP_FLIP: begin
          new_bit = ~cur_bit;
          bit_wr  = 1'b1;
        end
        btme_pkg::OP_READ: begin
          // buffer exhausted: take the offered byte
          if (in_cnt[3]) begin
            in_buf_next    = item.in_byte;
            res.byte_taken = 1'b1;
            new_bit        = item.in_byte[0];
            in_cnt_next    = 4'd1;
          end else begin
            new_bit     = in_buf[in_cnt[2:0]];
            in_cnt_next = in_cnt + 1'b1;
          end
          bit_wr = 1'b1;
        end
        btme_pkg::OP_WRITE: begin
          out_buf_next          = out_buf;
          out_buf_next[out_cnt] = cur_bit;
          if (out_cnt == 3'd7) begin
            res.out_valid = 1'b1;
            res.out_byte  = out_buf_next;
            out_buf_next  = '0;
            out_cnt_next  = '0;
          end else begin
            out_cnt_next = out_cnt + 1'b1;
          end
        end
        btme_pkg::OP_LEFT: begin
          cursor_next = cursor - 1'b1;
        end
        btme_pkg::OP_RIGHT: begin
          cursor_next = cursor + 1'b1;
        end
        btme_pkg::OP_LOOP: begin
          if (cur_bit) begin
            if (level == btme_pkg::LEVEL_BITS'(btme_pkg::STACK_DEPTH)) begin
              res.stack_overflow = 1'b1;
            end else begin
              push       = 1'b1;
              level_next = level + 1'b1;
            end
          end else begin
            skip_active_next = 1'b1;
            skip_depth_next  = '0;
          end
        end
        btme_pkg::OP_END: begin
          if (level != '0) begin
            if (cur_bit) begin
              res.next_pc = stack[top_idx] + 1'b1;
            end else begin
              level_next = level - 1'b1;
            end
          end
        end
        default: begin
        end
      endcase
    end
    res.skipping = skip_active_next;
  end

  // byte with the addressed bit replaced
  always_comb begin
    byte_wr          = rd_data;
    byte_wr[bit_sel] = new_bit;
  end

  always_comb begin
    tape_req.rd_en   = start;
    tape_req.rd_addr = cursor[btme_pkg::CURSOR_BITS-1:3];
    tape_req.wr_en   = fire && bit_wr;
    tape_req.wr_addr = cursor[btme_pkg::CURSOR_BITS-1:3];
    tape_req.wr_data = byte_wr;
  end

  always_ff @(posedge clk) begin
    if (start) begin
      item <= cmd;
    end
    if (fire && push) begin
      stack[level[btme_pkg::STACK_IDX_BITS-1:0]] <= item.pc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ex_valid    <= 1'b0;
      cursor      <= '0;
      level       <= '0;
      in_buf      <= '0;
      in_cnt      <= 4'd8;
      out_buf     <= '0;
      out_cnt     <= '0;
      skip_active <= 1'b0;
      skip_depth  <= '0;
    end else begin
      if (start) begin
        ex_valid <= 1'b1;
      end else if (fire) begin
        ex_valid <= 1'b0;
      end
      if (fire) begin
        cursor      <= cursor_next;
        level       <= level_next;
        in_buf      <= in_buf_next;
        in_cnt      <= in_cnt_next;
        out_buf     <= out_buf_next;
        out_cnt     <= out_cnt_next;
        skip_active <= skip_active_next;
        skip_depth  <= skip_depth_next;
      end
    end
  end

endmodule

// ----- rtl/bit_tape_machine_executor.sv -----
// top level of the bit tape executor: tape clearing, core and result register
//
// usage
//   cmd channel (cmd_valid/cmd_ready/cmd) takes one instruction word: the
//   instruction character, its program address and the next input byte
//   (0 at end of input). res channel (res_valid/res_ready/res) returns one
//   word per instruction: next fetch address, completed output byte, input
//   byte consumed, stack overflow and skip status.
//   an accepted word is registered with the tape byte under the cursor and
//   executes from those registers; its result enters the result register
//   once that is free. A new instruction is taken only after the previous one
//   has executed: the byte is read when a word is accepted, modified and
//   written back when it executes, and the next read needs the new cursor.
//   reset: rst clears all control state, then a clearing pass writes zero
//   to every tape byte, during which cmd_ready stays low.
//   stall: a result waits in the output register; one more instruction is
//   still accepted and held in the execute stage until the register frees.
module bit_tape_machine_executor (
  input  logic                clk,
  input  logic                rst,
  input  logic                cmd_valid,
  output logic                cmd_ready,
  input  btme_pkg::in_word_t  cmd,
  output logic                res_valid,
  input  logic                res_ready,
  output btme_pkg::out_word_t res
);

  // clearing pass state
  logic                                clearing;
  logic [btme_pkg::TAPE_ADDR_BITS-1:0] clr_addr;

  // core interface
  btme_pkg::tape_req_t core_req;
  btme_pkg::tape_req_t ram_req;
  btme_pkg::out_word_t core_res;
  logic [7:0]          rd_data;
  logic                start;
  logic                busy;
  logic                fire;
  logic                res_free;

  // output register frees when empty or being drained this cycle
  assign res_free  = !res_valid || res_ready;
  // a new word enters only when the execute stage is empty and the tape is clean
  assign cmd_ready = !clearing && !busy;
  assign start     = cmd_valid && cmd_ready;

  // clearing pass owns the write port until it is done
  always_comb begin
    ram_req = core_req;
    if (clearing) begin
      ram_req.wr_en   = 1'b1;
      ram_req.wr_addr = clr_addr;
      ram_req.wr_data = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + 1'b1;
      if (clr_addr == '1) begin
        clearing <= 1'b0;
      end
    end
  end

  btme_tape_ram u_tape (
    .clk     (clk),
    .req     (ram_req),
    .rd_data (rd_data)
  );

  btme_core u_core (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .cmd      (cmd),
    .res_free (res_free),
    .rd_data  (rd_data),
    .tape_req (core_req),
    .busy     (busy),
    .fire     (fire),
    .res      (core_res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (fire) begin
      res <= core_res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (fire) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

endmodule

// ----- sim/tb_bit_tape_machine_executor.sv -----
// testbench of the bit tape executor: step scoreboard, word drivers and result checks
module tb_bit_tape_machine_executor;

  localparam int          TAPE_BITS   = btme_pkg::TAPE_BYTES * 8;
  localparam int unsigned SKIP_TOP    = (1 << btme_pkg::SKIP_BITS) - 1;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int          TOTAL_ITEMS = 1100;
  localparam int          MAX_SHOWN   = 10;

  // tracks the executor's architectural state and queues the word each step must return
  class tape_tracker;
    btme_pkg::out_word_t          due_results[$];
    bit [7:0]                     tape_mem [btme_pkg::TAPE_BYTES];
    int unsigned                  head;
    logic [btme_pkg::PC_BITS-1:0] loop_addr [btme_pkg::STACK_DEPTH];
    int unsigned                  loop_level;
    bit [7:0]                     rd_buf;
    int unsigned                  rd_cnt;
    bit [7:0]                     wr_buf;
    int unsigned                  wr_cnt;
    bit                           skip_on;
    int unsigned                  skip_lvl;
    logic [btme_pkg::PC_BITS-1:0] fetch_pc;
    int unsigned                  fail_count;

    function new();
      head       = 0;
      loop_level = 0;
      rd_buf     = '0;
      rd_cnt     = 8;
      wr_buf     = '0;
      wr_cnt     = 0;
      skip_on    = 1'b0;
      skip_lvl   = 0;
      fetch_pc   = '0;
      fail_count = 0;
    endfunction

    function bit cur_bit();
      return tape_mem[head / 8][head % 8];
    endfunction

    function void put_bit(bit v);
      tape_mem[head / 8][head % 8] = v;
    endfunction

    // advance the state by one instruction word and queue the word it must return
    function void note_cmd(btme_pkg::in_word_t w);
      btme_pkg::out_word_t e;
      e         = '0;
      e.next_pc = w.pc + 1'b1;
      if (skip_on) begin
        if (w.kind == btme_pkg::OP_LOOP) begin
          if (skip_lvl != SKIP_TOP) skip_lvl++;
        end else if (w.kind == btme_pkg::OP_END) begin
          if (skip_lvl == 0) skip_on = 1'b0;
          else skip_lvl--;
        end
      end else begin
        case (w.kind)
          btme_pkg::OP_FLIP: put_bit(!cur_bit());
          btme_pkg::OP_READ: begin
            if (rd_cnt == 8) begin
              rd_buf       = w.in_byte;
              rd_cnt       = 0;
              e.byte_taken = 1'b1;
            end
            put_bit(rd_buf[rd_cnt]);
            rd_cnt++;
          end
          btme_pkg::OP_WRITE: begin
            wr_buf[wr_cnt] = cur_bit();
            wr_cnt++;
            if (wr_cnt == 8) begin
              e.out_valid = 1'b1;
              e.out_byte  = wr_buf;
              wr_buf      = '0;
              wr_cnt      = 0;
            end
          end
          btme_pkg::OP_LEFT:  head = (head == 0) ? TAPE_BITS - 1 : head - 1;
          btme_pkg::OP_RIGHT: head = (head == TAPE_BITS - 1) ? 0 : head + 1;
          btme_pkg::OP_LOOP: begin
            if (cur_bit()) begin
              if (loop_level < btme_pkg::STACK_DEPTH) begin
                loop_addr[loop_level] = w.pc;
                loop_level++;
              end else begin
                e.stack_overflow = 1'b1;
              end
            end else begin
              skip_on  = 1'b1;
              skip_lvl = 0;
            end
          end
          btme_pkg::OP_END: begin
            if (loop_level > 0) begin
              if (cur_bit()) e.next_pc = loop_addr[loop_level - 1] + 1'b1;
              else loop_level--;
            end
          end
          default: begin
          end
        endcase
      end
      e.skipping = skip_on;
      fetch_pc   = e.next_pc;
      due_results.push_back(e);
    endfunction

    function void check_res(btme_pkg::out_word_t r);
      btme_pkg::out_word_t e;
      if (due_results.size() == 0) begin
        fail_count++;
        if (fail_count <= MAX_SHOWN)
          $display("mismatch: result %h arrived with nothing pending", r);
        return;
      end
      e = due_results.pop_front();
      if (r.next_pc !== e.next_pc || r.out_valid !== e.out_valid ||
          r.out_byte !== e.out_byte || r.byte_taken !== e.byte_taken ||
          r.stack_overflow !== e.stack_overflow || r.skipping !== e.skipping) begin
        fail_count++;
        if (fail_count <= MAX_SHOWN) begin
          $display("mismatch: next_pc %h/%h out_valid %b/%b out_byte %h/%h (want/got)",
                   e.next_pc, r.next_pc, e.out_valid, r.out_valid, e.out_byte, r.out_byte);
          $display("  byte_taken %b/%b stack_overflow %b/%b skipping %b/%b (want/got)",
                   e.byte_taken, r.byte_taken, e.stack_overflow, r.stack_overflow,
                   e.skipping, r.skipping);
        end
      end
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst;
  logic                cmd_valid;
  logic                cmd_ready;
  btme_pkg::in_word_t  cmd;
  logic                res_valid;
  logic                res_ready;
  btme_pkg::out_word_t res;

  tape_tracker sb;
  int          send_gap_max;
  int          recv_stall_max;
  int          sent_count;
  int unsigned cycles;

  bit_tape_machine_executor dut (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // one word per call: optional idle gap, then valid held until cmd_ready
  task automatic send_word(input btme_pkg::in_word_t w);
    int gap;
    gap = $urandom_range(0, send_gap_max);
    if (gap > 0) begin
      cmd_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd_valid <= 1'b1;
    cmd       <= w;
    @(posedge clk);
    while (!cmd_ready) @(posedge clk);
    // accepted at this edge, so the step is predicted now
    sb.note_cmd(w);
    sent_count++;
  endtask

  task automatic send_at(input logic [7:0] kind, input logic [btme_pkg::PC_BITS-1:0] pc,
                         input logic [7:0] in_byte);
    btme_pkg::in_word_t w;
    w.kind    = kind;
    w.pc      = pc;
    w.in_byte = in_byte;
    send_word(w);
  endtask

  // behaves like a fetcher most of the time: follows next_pc, sometimes jumps anywhere
  task automatic issue(input logic [7:0] kind);
    logic [btme_pkg::PC_BITS-1:0] pc;
    pc = ($urandom_range(0, 99) < 85) ? sb.fetch_pc : btme_pkg::PC_BITS'($urandom);
    send_at(kind, pc, 8'($urandom));
  endtask

  // close any open skip region so the next sequence starts in normal execution
  task automatic leave_skip();
    while (sb.skip_on) issue(btme_pkg::OP_END);
  endtask

  function automatic logic [7:0] pick_kind();
    int r;
    r = $urandom_range(0, 99);
    if (r < 15) return btme_pkg::OP_FLIP;
    if (r < 27) return btme_pkg::OP_READ;
    if (r < 42) return btme_pkg::OP_WRITE;
    if (r < 52) return btme_pkg::OP_LEFT;
    if (r < 64) return btme_pkg::OP_RIGHT;
    if (r < 76) return btme_pkg::OP_LOOP;
    if (r < 90) return btme_pkg::OP_END;
    return 8'($urandom_range(0, 255));
  endfunction

  // result side: random stall before each word, ready then held until it is taken
  initial begin
    int stall;
    res_ready <= 1'b0;
    @(negedge rst);
    @(posedge clk);
    forever begin
      stall = $urandom_range(0, recv_stall_max);
      if (stall > 0) begin
        res_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      res_ready <= 1'b1;
      @(posedge clk);
      while (!res_valid) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if (!rst && res_valid && res_ready) sb.check_res(res);
  end

  // watchdog: covers the clearing pass and every word under the longest idling
  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("tb: failure");
    $finish;
  end

  initial begin
    int seq_kind;
    int n;
    sb             = new();
    send_gap_max   = 3;
    recv_stall_max = 3;
    sent_count     = 0;
    rst       <= 1'b1;
    cmd_valid <= 1'b0;
    cmd       <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // directed: the buffer is empty after reset, so the first read takes in_byte
    send_at(btme_pkg::OP_READ, 16'h0000, 8'hFF);
    // taken loop at the top address, then a jump back that wraps next_pc to zero
    send_at(btme_pkg::OP_LOOP, 16'hFFFF, 8'h00);
    send_at(btme_pkg::OP_END,  16'h0005, 8'h00);
    // clear the bit, then the loop end pops; a second one meets an empty stack
    send_at(btme_pkg::OP_FLIP, 16'h0006, 8'h00);
    send_at(btme_pkg::OP_END,  16'h0007, 8'h00);
    send_at(btme_pkg::OP_END,  16'h0008, 8'h00);
    // left edge of the circular tape, write the last bit out, wrap back right
    send_at(btme_pkg::OP_LEFT,  16'h0009, 8'h00);
    send_at(btme_pkg::OP_FLIP,  16'h000A, 8'h00);
    send_at(btme_pkg::OP_WRITE, 16'h000B, 8'h00);
    send_at(btme_pkg::OP_RIGHT, 16'h000C, 8'h00);
    // bit under the head is zero here: the loop is skipped, with one nested pair inside
    send_at(btme_pkg::OP_LOOP, 16'h000D, 8'h00);
    send_at(btme_pkg::OP_FLIP, 16'h000E, 8'h00);
    send_at(btme_pkg::OP_LOOP, 16'h000F, 8'h00);
    send_at(btme_pkg::OP_END,  16'h0010, 8'h00);
    send_at(btme_pkg::OP_END,  16'h0011, 8'h00);
    // characters that are not instructions
    send_at(8'h00, 16'h0012, 8'h00);
    send_at(8'hFF, 16'h0013, 8'hFF);
    send_at(8'h61, 16'h0014, 8'h00);
    // drain the input byte, then the exhausted buffer takes the end-of-input zero
    repeat (7) issue(btme_pkg::OP_READ);
    send_at(btme_pkg::OP_READ, sb.fetch_pc, 8'h00);

    // random part, built from short sequences so loops and buffers get exercised
    while (sent_count < TOTAL_ITEMS) begin
      seq_kind = $urandom_range(0, 99);
      if (seq_kind < 50) begin
        repeat ($urandom_range(8, 24)) issue(pick_kind());
      end else if (seq_kind < 65) begin
        // echo: each input bit goes straight back out, so whole bytes come out
        leave_skip();
        repeat (8) begin
          issue(btme_pkg::OP_READ);
          issue(btme_pkg::OP_WRITE);
          issue(btme_pkg::OP_RIGHT);
        end
      end else if (seq_kind < 80) begin
        // nested taken loops, deep enough at times to overflow the stack
        leave_skip();
        n = $urandom_range(1, 20);
        if (!sb.cur_bit()) issue(btme_pkg::OP_FLIP);
        repeat (n) issue(btme_pkg::OP_LOOP);
        repeat ($urandom_range(0, 3)) issue(btme_pkg::OP_END);
        issue(btme_pkg::OP_FLIP);
        repeat (n) issue(btme_pkg::OP_END);
      end else if (seq_kind < 90) begin
        // loop not taken, with random nesting and junk inside the skipped body
        leave_skip();
        if (sb.cur_bit()) issue(btme_pkg::OP_FLIP);
        issue(btme_pkg::OP_LOOP);
        repeat ($urandom_range(4, 20)) begin
          case ($urandom_range(0, 3))
            0:       issue(btme_pkg::OP_LOOP);
            1:       issue(btme_pkg::OP_END);
            2:       issue(pick_kind());
            default: issue(8'($urandom_range(0, 255)));
          endcase
        end
        leave_skip();
      end else begin
        repeat ($urandom_range(4, 10))
          send_at(8'($urandom_range(0, 255)), btme_pkg::PC_BITS'($urandom), 8'($urandom));
      end
    end

    cmd_valid <= 1'b0;
    while (sb.due_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    if (sb.fail_count == 0 && sb.due_results.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
